/* rtl/tor_pkg.sv */
// ----------------------------------------------------------------------------
// tor_pkg: shared types and constants of the tile order address remap
// Field widths, register indexes, the pipeline item carried through the
// dividers, and small helpers for register clamping and edge tile clipping.
// ----------------------------------------------------------------------------
`default_nettype none

package tor_pkg;

  localparam int POS_W          = 26;
  localparam int DIM_W          = 13;
  localparam int CNT_W          = 3;
  localparam int COL_W          = 2;
  localparam int PROD_W         = 27;
  localparam int TOTAL_W        = 27;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;
  localparam int DIV_STAGES     = POS_W;

  localparam logic [DIM_W-1:0] MAX_WIDTH      = DIM_W'(4096);
  localparam logic [DIM_W-1:0] MAX_HEIGHT     = DIM_W'(4096);
  localparam logic [CNT_W-1:0] MAX_COMPONENTS = CNT_W'(4);
  localparam logic [DIM_W-1:0] MAX_TILE       = {DIM_W{1'b1}};

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_COMPONENT_COUNT = 3'd2;
  localparam logic [2:0] REG_TILE_WIDTH      = 3'd3;
  localparam logic [2:0] REG_TILE_HEIGHT     = 3'd4;

  localparam logic OP_RASTER_TO_TILE = 1'b0;
  localparam logic OP_TILE_TO_RASTER = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [DIM_W-1:0]   tw;
    logic [DIM_W-1:0]   th;
    logic [CNT_W-1:0]   c;
    logic [POS_W-1:0]   row_len;
    logic [TOTAL_W-1:0] total;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              op;
    logic              oor;
    logic [COL_W-1:0]  col;
    logic [POS_W-1:0]  q1;
    logic [POS_W-1:0]  r1;
    logic [POS_W-1:0]  q2;
    logic [POS_W-1:0]  r2;
    logic [DIM_W-1:0]  ysz;
    logic [POS_W-1:0]  full;
    logic [DIM_W-1:0]  xsz;
    logic [PROD_W-1:0] prod;
  } item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] vmax);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > vmax) r = vmax;
    else r = v;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) r = CNT_W'(1);
    else if (v > MAX_COMPONENTS) r = MAX_COMPONENTS;
    else r = v;
    return r;
  endfunction

  // (id + 1) * nominal, taken from a 13-bit tile index
  function automatic logic [PROD_W-1:0] clip_prod(input logic [DIM_W-1:0] id,
                                                  input logic [DIM_W-1:0] nom);
    logic [PROD_W-1:0] r;
    r = (PROD_W'(id) + PROD_W'(1)) * PROD_W'(nom);
    return r;
  endfunction

  // edge tile size from (id + 1) * nominal
  function automatic logic [DIM_W-1:0] clip_size(input logic [PROD_W-1:0] prod,
                                                 input logic [DIM_W-1:0] nom,
                                                 input logic [DIM_W-1:0] ext);
    logic [PROD_W-1:0] start;
    logic [PROD_W-1:0] left;
    logic [DIM_W-1:0]  r;
    start = prod - PROD_W'(nom);
    left  = PROD_W'(ext) - start;
    if (prod > PROD_W'(ext)) r = left[DIM_W-1:0];
    else r = nom;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/tor_cfg.sv */
// ----------------------------------------------------------------------------
// tor_cfg: configuration registers
// APB-style register file for image and tile geometry, with clamped views
// and registered products used by the remap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tor_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tor_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tor_pkg::DATA_W-1:0] pwdata,
  output logic      [tor_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output tor_pkg::cfg_t                   cfg
);

  logic [tor_pkg::DIM_W-1:0]   image_width;
  logic [tor_pkg::DIM_W-1:0]   image_height;
  logic [tor_pkg::CNT_W-1:0]   component_count;
  logic [tor_pkg::DIM_W-1:0]   tile_width;
  logic [tor_pkg::DIM_W-1:0]   tile_height;
  logic [tor_pkg::POS_W-1:0]   row_len;
  logic [tor_pkg::POS_W-1:0]   wh;
  logic [tor_pkg::TOTAL_W-1:0] total;
  logic [2:0]                  idx;
  logic                        wr;
  logic [tor_pkg::DIM_W-1:0]   w;
  logic [tor_pkg::DIM_W-1:0]   h;
  logic [tor_pkg::DIM_W-1:0]   tw;
  logic [tor_pkg::DIM_W-1:0]   th;
  logic [tor_pkg::CNT_W-1:0]   c;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= tor_pkg::DIM_W'(1);
      image_height    <= tor_pkg::DIM_W'(1);
      component_count <= tor_pkg::CNT_W'(1);
      tile_width      <= tor_pkg::DIM_W'(1);
      tile_height     <= tor_pkg::DIM_W'(1);
    end else if (wr) begin
      unique case (idx)
        tor_pkg::REG_IMAGE_WIDTH:     image_width     <= pwdata[tor_pkg::DIM_W-1:0];
        tor_pkg::REG_IMAGE_HEIGHT:    image_height    <= pwdata[tor_pkg::DIM_W-1:0];
        tor_pkg::REG_COMPONENT_COUNT: component_count <= pwdata[tor_pkg::CNT_W-1:0];
        tor_pkg::REG_TILE_WIDTH:      tile_width      <= pwdata[tor_pkg::DIM_W-1:0];
        tor_pkg::REG_TILE_HEIGHT:     tile_height     <= pwdata[tor_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tor_pkg::REG_IMAGE_WIDTH:     prdata = tor_pkg::DATA_W'(image_width);
      tor_pkg::REG_IMAGE_HEIGHT:    prdata = tor_pkg::DATA_W'(image_height);
      tor_pkg::REG_COMPONENT_COUNT: prdata = tor_pkg::DATA_W'(component_count);
      tor_pkg::REG_TILE_WIDTH:      prdata = tor_pkg::DATA_W'(tile_width);
      tor_pkg::REG_TILE_HEIGHT:     prdata = tor_pkg::DATA_W'(tile_height);
      default:                      prdata = '0;
    endcase
  end

  assign w  = tor_pkg::clamp_dim(image_width, tor_pkg::MAX_WIDTH);
  assign h  = tor_pkg::clamp_dim(image_height, tor_pkg::MAX_HEIGHT);
  assign tw = tor_pkg::clamp_dim(tile_width, tor_pkg::MAX_TILE);
  assign th = tor_pkg::clamp_dim(tile_height, tor_pkg::MAX_TILE);
  assign c  = tor_pkg::clamp_cnt(component_count);

  // products are registered; total is taken from the registered w * h product
  always_ff @(posedge clk) begin
    row_len <= tor_pkg::POS_W'(th) * tor_pkg::POS_W'(w);
    wh      <= tor_pkg::POS_W'(w) * tor_pkg::POS_W'(h);
    total   <= tor_pkg::TOTAL_W'(wh) * tor_pkg::TOTAL_W'(c);
  end

  always_comb begin
    cfg.w       = w;
    cfg.h       = h;
    cfg.tw      = tw;
    cfg.th      = th;
    cfg.c       = c;
    cfg.row_len = row_len;
    cfg.total   = total;
  end

endmodule

`default_nettype wire

/* rtl/tor_div.sv */
// ----------------------------------------------------------------------------
// tor_div: pipelined restoring divider
// One quotient bit per stage, 26 stages; the pipeline item travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tor_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic [tor_pkg::POS_W-1:0] dividend,
  input  wire logic [tor_pkg::POS_W-1:0] divisor,
  input  tor_pkg::item_t                 item_in,
  output logic      [tor_pkg::POS_W-1:0] quotient,
  output logic      [tor_pkg::POS_W-1:0] remainder,
  output tor_pkg::item_t                 item_out
);

  logic [tor_pkg::POS_W-1:0] rem_q  [tor_pkg::DIV_STAGES];
  logic [tor_pkg::POS_W-1:0] num_q  [tor_pkg::DIV_STAGES];
  logic [tor_pkg::POS_W-1:0] den_q  [tor_pkg::DIV_STAGES];
  logic [tor_pkg::POS_W-1:0] quo_q  [tor_pkg::DIV_STAGES];
  tor_pkg::item_t            item_q [tor_pkg::DIV_STAGES];

  for (genvar k = 0; k < tor_pkg::DIV_STAGES; k++) begin : g_stage
    logic [tor_pkg::POS_W-1:0] p_rem;
    logic [tor_pkg::POS_W-1:0] p_num;
    logic [tor_pkg::POS_W-1:0] p_den;
    logic [tor_pkg::POS_W-1:0] p_quo;
    tor_pkg::item_t            p_item;
    logic [tor_pkg::POS_W:0]   trial;
    logic [tor_pkg::POS_W:0]   diff;
    logic                      ge;

    if (k == 0) begin : g_src
      assign p_rem  = '0;
      assign p_num  = dividend;
      assign p_den  = divisor;
      assign p_quo  = '0;
      assign p_item = item_in;
    end else begin : g_src
      assign p_rem  = rem_q[k-1];
      assign p_num  = num_q[k-1];
      assign p_den  = den_q[k-1];
      assign p_quo  = quo_q[k-1];
      assign p_item = item_q[k-1];
    end

    assign trial = {p_rem, p_num[tor_pkg::POS_W-1-k]};
    assign diff  = trial - {1'b0, p_den};
    assign ge    = trial >= {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        item_q[k].valid <= 1'b0;
      end else if (en) begin
        item_q[k] <= p_item;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[tor_pkg::POS_W-1:0] : trial[tor_pkg::POS_W-1:0];
        num_q[k] <= p_num;
        den_q[k] <= p_den;
        quo_q[k] <= {p_quo[tor_pkg::POS_W-2:0], ge};
      end
    end
  end

  assign quotient  = quo_q[tor_pkg::DIV_STAGES-1];
  assign remainder = rem_q[tor_pkg::DIV_STAGES-1];
  assign item_out  = item_q[tor_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

/* rtl/tile_order_address_remap.sv */
// ----------------------------------------------------------------------------
// tile_order_address_remap: raster / tile order position remap
// Four 26-stage dividers plus 12 register stages lie between input beat
// and output beat. Throughput: one beat per cycle while not stalled.
// A stalled output beat holds the whole pipeline for that cycle.
// Reset clears all valid bits; registers come up as width, height,
// components, tile width and tile height of 1.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_order_address_remap (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tor_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tor_pkg::DATA_W-1:0] pwdata,
  output logic      [tor_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       opcode,
  input  wire logic [tor_pkg::POS_W-1:0]  position,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [tor_pkg::POS_W-1:0]  mapped_position,
  output logic                            out_of_range
);

  typedef struct packed {
    logic                       valid;
    logic                       op;
    logic                       oor;
    logic [tor_pkg::COL_W-1:0]  col;
    logic [tor_pkg::POS_W-1:0]  a;
    logic [tor_pkg::POS_W-1:0]  txtw;
    logic [tor_pkg::POS_W-1:0]  oyx;
    logic [tor_pkg::POS_W-1:0]  ox;
    logic [tor_pkg::PROD_W-1:0] prody;
    logic [tor_pkg::DIM_W-1:0]  ysz;
    logic [tor_pkg::POS_W-1:0]  sum;
    logic [tor_pkg::POS_W-1:0]  b;
  } tail_t;

  tor_pkg::cfg_t             cfg;
  logic                      en;
  logic                      s0_valid, s1_valid;
  logic                      s0_op, s1_op;
  logic [tor_pkg::POS_W-1:0] s0_pos, s1_pos;

  tor_pkg::item_t            d0_in, d0_out, d1_in, d1_out, d2_in, d2_out, d3_in, d3_out;
  logic [tor_pkg::POS_W-1:0] d0_q, d0_r, d1_q, d1_r, d2_q, d2_r, d3_q, d3_r;
  logic [tor_pkg::POS_W-1:0] d1_den, d2_den, d3_num, d3_den;
  tor_pkg::item_t            m1, m2, m3, n1, n2;
  tor_pkg::item_t            m1_next, m2_next, m3_next, n1_next, n2_next;
  tail_t                     f1, f2, f3, f4;
  tail_t                     f1_next, f2_next, f3_next, f4_next;
  logic [tor_pkg::DIM_W-1:0] ty, tx, oy;
  logic [tor_pkg::POS_W-1:0] ox;

  tor_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // advance everything unless the output beat is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_op  <= opcode;
      s0_pos <= position;
      s1_op  <= s0_op;
      s1_pos <= s0_pos;
    end
  end

  // pixel and component split
  always_comb begin
    d0_in       = '0;
    d0_in.valid = s1_valid;
    d0_in.op    = s1_op;
    d0_in.oor   = tor_pkg::TOTAL_W'(s1_pos) >= cfg.total;
  end

  tor_div u_div0 (
    .clk (clk), .rst (rst), .en (en),
    .dividend (s1_pos), .divisor (tor_pkg::POS_W'(cfg.c)), .item_in (d0_in),
    .quotient (d0_q), .remainder (d0_r), .item_out (d0_out)
  );

  // tile row / image row split
  always_comb begin
    d1_in     = d0_out;
    d1_in.col = d0_r[tor_pkg::COL_W-1:0];
    d1_den    = (d0_out.op == tor_pkg::OP_TILE_TO_RASTER) ? cfg.row_len
                                                            : tor_pkg::POS_W'(cfg.w);
  end

  tor_div u_div1 (
    .clk (clk), .rst (rst), .en (en),
    .dividend (d0_q), .divisor (d1_den), .item_in (d1_in),
    .quotient (d1_q), .remainder (d1_r), .item_out (d1_out)
  );

  // clipped tile row height and tile size for the tile order source
  always_comb begin
    m1_next      = d1_out;
    m1_next.q1   = d1_q;
    m1_next.r1   = d1_r;
    m1_next.prod = tor_pkg::clip_prod(d1_q[tor_pkg::DIM_W-1:0], cfg.th);
    m2_next      = m1;
    m2_next.ysz  = tor_pkg::clip_size(m1.prod, cfg.th, cfg.h);
    m3_next      = m2;
    m3_next.full = tor_pkg::POS_W'(m2.ysz) * tor_pkg::POS_W'(cfg.tw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1.valid <= 1'b0;
      m2.valid <= 1'b0;
      m3.valid <= 1'b0;
    end else if (en) begin
      m1 <= m1_next;
      m2 <= m2_next;
      m3 <= m3_next;
    end
  end

  always_comb begin
    d2_in  = m3;
    d2_den = (m3.op == tor_pkg::OP_TILE_TO_RASTER) ? m3.full : tor_pkg::POS_W'(cfg.tw);
  end

  tor_div u_div2 (
    .clk (clk), .rst (rst), .en (en),
    .dividend (m3.r1), .divisor (d2_den), .item_in (d2_in),
    .quotient (d2_q), .remainder (d2_r), .item_out (d2_out)
  );

  // clipped tile width
  always_comb begin
    n1_next      = d2_out;
    n1_next.q2   = d2_q;
    n1_next.r2   = d2_r;
    n1_next.prod = tor_pkg::clip_prod(d2_q[tor_pkg::DIM_W-1:0], cfg.tw);
    n2_next      = n1;
    n2_next.xsz  = tor_pkg::clip_size(n1.prod, cfg.tw, cfg.w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1.valid <= 1'b0;
      n2.valid <= 1'b0;
    end else if (en) begin
      n1 <= n1_next;
      n2 <= n2_next;
    end
  end

  always_comb begin
    d3_in = n2;
    if (n2.op == tor_pkg::OP_TILE_TO_RASTER) begin
      d3_num = n2.r2;
      d3_den = tor_pkg::POS_W'(n2.xsz);
    end else begin
      d3_num = n2.q1;
      d3_den = tor_pkg::POS_W'(cfg.th);
    end
  end

  tor_div u_div3 (
    .clk (clk), .rst (rst), .en (en),
    .dividend (d3_num), .divisor (d3_den), .item_in (d3_in),
    .quotient (d3_q), .remainder (d3_r), .item_out (d3_out)
  );

  // tile and in-tile coordinates
  always_comb begin
    tx = d3_out.q2[tor_pkg::DIM_W-1:0];
    if (d3_out.op == tor_pkg::OP_TILE_TO_RASTER) begin
      ty = d3_out.q1[tor_pkg::DIM_W-1:0];
      oy = d3_q[tor_pkg::DIM_W-1:0];
      ox = d3_r;
    end else begin
      ty = d3_q[tor_pkg::DIM_W-1:0];
      oy = d3_r[tor_pkg::DIM_W-1:0];
      ox = d3_out.r2;
    end
  end

  always_comb begin
    f1_next       = '0;
    f1_next.valid = d3_out.valid;
    f1_next.op    = d3_out.op;
    f1_next.oor   = d3_out.oor;
    f1_next.col   = d3_out.col;
    f1_next.a     = tor_pkg::POS_W'(tor_pkg::POS_W'(ty) * cfg.row_len);
    f1_next.txtw  = tor_pkg::POS_W'(tx) * tor_pkg::POS_W'(cfg.tw);
    f1_next.oyx   = (d3_out.op == tor_pkg::OP_TILE_TO_RASTER)
                    ? tor_pkg::POS_W'(oy) * tor_pkg::POS_W'(cfg.w)
                    : tor_pkg::POS_W'(oy) * tor_pkg::POS_W'(d3_out.xsz);
    f1_next.ox    = ox;
    f1_next.prody = tor_pkg::clip_prod(ty, cfg.th);

    f2_next       = f1;
    f2_next.ysz   = tor_pkg::clip_size(f1.prody, cfg.th, cfg.h);
    f2_next.sum   = f1.a + f1.oyx + f1.ox;

    f3_next       = f2;
    f3_next.b     = (f2.op == tor_pkg::OP_TILE_TO_RASTER)
                    ? f2.txtw
                    : tor_pkg::POS_W'(tor_pkg::POS_W'(f2.ysz) * f2.txtw);

    f4_next       = f3;
    f4_next.sum   = f3.sum + f3.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1.valid  <= 1'b0;
      f2.valid  <= 1'b0;
      f3.valid  <= 1'b0;
      f4.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f1              <= f1_next;
      f2              <= f2_next;
      f3              <= f3_next;
      f4              <= f4_next;
      out_valid       <= f4.valid;
      out_of_range    <= f4.oor;
      mapped_position <= f4.oor ? '0
                         : tor_pkg::POS_W'(f4.sum * tor_pkg::POS_W'(cfg.c)
                                           + tor_pkg::POS_W'(f4.col));
    end
  end

endmodule

`default_nettype wire
